### design/cfcf_pkg.sv
package cfcf_pkg;

	localparam int ID_W      = 29;
	localparam int KEY_W     = 16;
	localparam int HDR_W     = 37;
	localparam int PAY_W     = 64;
	localparam int TIME_W    = 48;
	localparam int STATUS_W  = 3;
	localparam int CNT_W     = 32;
	localparam int LEVEL_W   = 9;
	localparam int IN_DATA_W = 152;
	localparam int OUT_DATA_W = 240;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [ID_W-1:0] OBD_REQUEST_ID = 29'h7DF;
	localparam logic [ID_W-1:0] OBD_RESP_FIRST = 29'h7E8;
	localparam logic [ID_W-1:0] OBD_RESP_LAST  = 29'h7EF;
	localparam logic [ID_W-1:0] STD_ID_MAX     = 29'h7FF;
	localparam logic [CNT_W-1:0] SAT32         = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_OFFER = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED     = 3'd0,
		ST_FILTERED   = 3'd1,
		ST_DISABLED   = 3'd2,
		ST_READ_VALID = 3'd3,
		ST_READ_EMPTY = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ID_LOW    = 3'd0,
		REG_ID_HIGH   = 3'd1,
		REG_DROP_REQ  = 3'd2,
		REG_DROP_RESP = 3'd3,
		REG_CAPTURE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_WRITE  = 5'b00100,
		S_READ   = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	typedef struct packed {
		logic            valid;
		logic            hit;
		logic [KEY_W-1:0] key;
	} probe_t;

endpackage

### design/cfcf_seen_cell.sv
module cfcf_seen_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 used,
	input  cfcf_pkg::probe_t     probe_in,
	output cfcf_pkg::probe_t     probe_out
);
	import cfcf_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic             used_q;
	logic             match;

	assign match = used_q && (key_q == probe_in.key);

	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= probe_in.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			probe_out <= '0;
		end else begin
			used_q          <= used;
			probe_out.valid <= probe_in.valid;
			probe_out.key   <= probe_in.key;
			probe_out.hit   <= probe_in.hit | match;
		end
	end

endmodule

### design/cfcf_seen_chain.sv
module cfcf_seen_chain #(
	parameter int SEEN_DEPTH = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [cfcf_pkg::KEY_W-1:0]   key,
	input  logic [$clog2(SEEN_DEPTH+1)-1:0] seen_count,
	input  logic                         insert,
	output logic                         done,
	output logic                         hit
);
	import cfcf_pkg::*;

	localparam int CW = $clog2(SEEN_DEPTH+1);

	probe_t chain [SEEN_DEPTH+1];
	logic [SEEN_DEPTH-1:0] used;

	assign chain[0].valid = start;
	assign chain[0].hit   = 1'b0;
	assign chain[0].key   = key;

	genvar g;
	generate
		for (g = 0; g < SEEN_DEPTH; g++) begin : g_cell
			logic load;
			assign used[g] = CW'(g) < seen_count;
			assign load    = insert && (CW'(g) == seen_count);
			cfcf_seen_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.load      (load),
				.used      (used[g] | load),
				.probe_in  (chain[g]),
				.probe_out (chain[g+1])
			);
		end
	endgenerate

	assign done = chain[SEEN_DEPTH].valid;
	assign hit  = chain[SEEN_DEPTH].hit;

endmodule

### design/cfcf_ring.sv
module cfcf_ring #(
	parameter int RING_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(RING_DEPTH)-1:0]       waddr,
	input  logic [cfcf_pkg::HDR_W+cfcf_pkg::PAY_W+cfcf_pkg::TIME_W-1:0] wdata,
	input  logic                                re,
	input  logic [$clog2(RING_DEPTH)-1:0]       raddr,
	output logic [cfcf_pkg::HDR_W+cfcf_pkg::PAY_W+cfcf_pkg::TIME_W-1:0] rdata
);
	import cfcf_pkg::*;

	logic [HDR_W+PAY_W+TIME_W-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/can_frame_capture_filter_unit.sv
// Steps: an offer that passes the filter goes from S_SEARCH, where the search walks the
// seen-ID cell chain one cell per cycle, to S_WRITE and S_OUT; a read of a stored frame
// goes through S_SEARCH, S_READ and S_OUT; every other item through S_SEARCH and S_OUT.
// Throughput: one item at a time; the next beat is taken once the result is loaded.
// The output register holds a result while the next item is accepted.
// Reset (arst_n low, asynchronous): registers to defaults, pointers and counts zero;
// frame ring and seen-ID keys are not cleared.
module can_frame_capture_filter_unit #(
	parameter int RING_DEPTH = 256,
	parameter int SEEN_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// action[1:0], frame_id[30:2], extended_flag[31], transmit_flag[32], bus_number[34:33],
	// length_code[38:35], payload_bytes[102:39], time_stamp[150:103], zero pad
	input  logic [cfcf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[2:0], read_id[31:3], read_extended[32], read_transmit[33], read_bus[35:34],
	// read_length[39:36], read_payload[103:40], read_time[151:104], fill_level[160:152],
	// overflow_count[192:161], distinct_ids[201:193], captured_count[233:202], zero pad
	output logic [cfcf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cfcf_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = $clog2(RING_DEPTH+1);
	localparam int SW = $clog2(SEEN_DEPTH+1);
	localparam int EW = HDR_W + PAY_W + TIME_W;

	logic [ID_W-1:0] id_low_q, id_high_q;
	logic            drop_req_q, drop_resp_q, capture_q;

	state_t          state_q;
	logic [1:0]      action_q;
	logic [ID_W-1:0] id_q;
	logic [EW-1:0]   entry_q;
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [FW-1:0]   fill_q;
	logic [SW-1:0]   seen_q;
	logic [CNT_W-1:0] ovf_q, cap_q;
	status_t         status_q;
	logic            rd_valid_q;
	logic            out_valid_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic            launched_q;

	logic            start, done, hit, insert, we, re, pass, out_load;
	logic [EW-1:0]   rdata;

	function automatic logic [AW-1:0] ptr_next(logic [AW-1:0] p);
		return (p == AW'(RING_DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_low_q    <= '0;
			id_high_q   <= STD_ID_MAX;
			drop_req_q  <= 1'b1;
			drop_resp_q <= 1'b0;
			capture_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ID_LOW:    id_low_q    <= cfg_data[ID_W-1:0];
				REG_ID_HIGH:   id_high_q   <= cfg_data[ID_W-1:0];
				REG_DROP_REQ:  drop_req_q  <= cfg_data[0];
				REG_DROP_RESP: drop_resp_q <= cfg_data[0];
				REG_CAPTURE:   capture_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		pass = (id_q >= id_low_q) && (id_q <= id_high_q);
		if (drop_req_q && id_q == OBD_REQUEST_ID) pass = 1'b0;
		if (drop_resp_q && id_q >= OBD_RESP_FIRST && id_q <= OBD_RESP_LAST) pass = 1'b0;
	end

	assign start  = (state_q == S_SEARCH) && !launched_q && pass && capture_q &&
		(action_q == ACT_OFFER);
	assign insert = done && !hit && (seen_q < SW'(SEEN_DEPTH));
	assign we     = (state_q == S_WRITE);
	assign re     = (state_q == S_READ);
	assign out_load = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

	cfcf_seen_chain #(.SEEN_DEPTH(SEEN_DEPTH)) u_seen (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.key        (id_q[KEY_W-1:0]),
		.seen_count (seen_q),
		.insert     (insert),
		.done       (done),
		.hit        (hit)
	);

	cfcf_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (wptr_q),
		.wdata (entry_q),
		.re    (re),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_q <= s_axis_tdata[1:0];
			id_q     <= s_axis_tdata[30:2];
			entry_q  <= {s_axis_tdata[150:103], s_axis_tdata[102:39], s_axis_tdata[38:35],
				s_axis_tdata[34:33], s_axis_tdata[32], s_axis_tdata[31], s_axis_tdata[30:2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wptr_q      <= '0;
			rptr_q      <= '0;
			fill_q      <= '0;
			seen_q      <= '0;
			ovf_q       <= '0;
			cap_q       <= '0;
			status_q    <= ST_DISABLED;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			launched_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					rd_valid_q <= 1'b0;
					case (action_q)
						ACT_OFFER: begin
							if (!capture_q) begin
								status_q <= ST_DISABLED;
								state_q  <= S_OUT;
							end else if (!pass) begin
								status_q <= ST_FILTERED;
								state_q  <= S_OUT;
							end else if (done) begin
								launched_q <= 1'b0;
								if (insert) seen_q <= seen_q + 1'b1;
								state_q <= S_WRITE;
							end else begin
								launched_q <= 1'b1;
							end
						end
						ACT_READ: begin
							if (fill_q == '0) begin
								status_q <= ST_READ_EMPTY;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_READ;
							end
						end
						ACT_CLEAR: begin
							wptr_q   <= '0;
							rptr_q   <= '0;
							fill_q   <= '0;
							seen_q   <= '0;
							ovf_q    <= '0;
							cap_q    <= '0;
							status_q <= ST_STORED;
							state_q  <= S_OUT;
						end
						default: begin
							status_q <= ST_DISABLED;
							state_q  <= S_OUT;
						end
					endcase
				end
				S_WRITE: begin
					if (fill_q == FW'(RING_DEPTH)) begin
						if (ovf_q != SAT32) ovf_q <= ovf_q + 1'b1;
						rptr_q <= ptr_next(rptr_q);
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					wptr_q <= ptr_next(wptr_q);
					if (cap_q != SAT32) cap_q <= cap_q + 1'b1;
					status_q <= ST_STORED;
					state_q  <= S_OUT;
				end
				S_READ: begin
					rptr_q     <= ptr_next(rptr_q);
					fill_q     <= fill_q - 1'b1;
					rd_valid_q <= 1'b1;
					status_q   <= ST_READ_VALID;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q <= {6'd0, cap_q, 9'(seen_q), ovf_q, 9'(fill_q),
							rd_valid_q ? rdata : {EW{1'b0}}, status_q};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

### sim/tb_can_frame_capture_filter_unit.sv
`timescale 1ns / 1ps

module tb_can_frame_capture_filter_unit;
	import cfcf_pkg::*;

	localparam int RING_N = 256;
	localparam int SEEN_N = 256;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		action_t      act;
		logic [28:0]  id;
		logic         ext;
		logic         tx;
		logic [1:0]   bus;
		logic [3:0]   len;
		logic [63:0]  pay;
		logic [47:0]  ts;
	} can_frame_t;

	typedef struct {
		logic [2:0]   status;
		logic [28:0]  id;
		logic         ext;
		logic         tx;
		logic [1:0]   bus;
		logic [3:0]   len;
		logic [63:0]  pay;
		logic [47:0]  ts;
		logic [8:0]   fill;
		logic [31:0]  ovf;
		logic [8:0]   seen;
		logic [31:0]  cap;
	} capture_result_t;

	typedef struct {
		bit           is_cfg;
		cfg_reg_t     reg_idx;
		logic [31:0]  reg_val;
		can_frame_t   frame;
		bit           has_status;
		status_t      status;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	can_frame_capture_filter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// filter settings and capture state
	logic [28:0] lo_bound, hi_bound;
	logic drop_req, drop_resp, cap_en;
	can_frame_t ring[RING_N];
	int wr_ptr, rd_ptr, fill_cnt, key_cnt;
	logic [15:0] keys[SEEN_N];
	logic [31:0] lost_total, stored_total;

	capture_result_t pending_q[$];
	bit failed;
	int src_pct, snk_pct, hold_left;
	longint cycles;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[can_frame_capture_filter_unit] ERROR");
			$finish;
		end
	end

	function automatic bit id_accepted(logic [28:0] id);
		if (id < lo_bound || id > hi_bound)
			return 0;
		if (drop_req && id == OBD_REQUEST_ID)
			return 0;
		if (drop_resp && id >= OBD_RESP_FIRST && id <= OBD_RESP_LAST)
			return 0;
		return 1;
	endfunction

	function automatic capture_result_t capture_step(can_frame_t f);
		capture_result_t r;
		bit known;
		r = '{default: '0};
		r.status = ST_DISABLED;
		case (f.act)
			ACT_OFFER: begin
				if (!cap_en)
					r.status = ST_DISABLED;
				else if (!id_accepted(f.id))
					r.status = ST_FILTERED;
				else begin
					known = 0;
					for (int i = 0; i < key_cnt; i++)
						if (keys[i] == f.id[15:0])
							known = 1;
					if (!known && key_cnt < SEEN_N) begin
						keys[key_cnt] = f.id[15:0];
						key_cnt++;
					end
					if (fill_cnt >= RING_N) begin
						if (lost_total != SAT32)
							lost_total++;
						rd_ptr = (rd_ptr + 1) % RING_N;
						fill_cnt--;
					end
					ring[wr_ptr] = f;
					wr_ptr = (wr_ptr + 1) % RING_N;
					fill_cnt++;
					if (stored_total != SAT32)
						stored_total++;
					r.status = ST_STORED;
				end
			end
			ACT_READ: begin
				if (fill_cnt == 0)
					r.status = ST_READ_EMPTY;
				else begin
					r.id = ring[rd_ptr].id;
					r.ext = ring[rd_ptr].ext;
					r.tx = ring[rd_ptr].tx;
					r.bus = ring[rd_ptr].bus;
					r.len = ring[rd_ptr].len;
					r.pay = ring[rd_ptr].pay;
					r.ts = ring[rd_ptr].ts;
					rd_ptr = (rd_ptr + 1) % RING_N;
					fill_cnt--;
					r.status = ST_READ_VALID;
				end
			end
			ACT_CLEAR: begin
				wr_ptr = 0;
				rd_ptr = 0;
				fill_cnt = 0;
				key_cnt = 0;
				lost_total = 0;
				stored_total = 0;
				r.status = ST_STORED;
			end
			default: r.status = ST_DISABLED;
		endcase
		r.fill = fill_cnt[8:0];
		r.ovf = lost_total;
		r.seen = key_cnt[8:0];
		r.cap = stored_total;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			failed = 1;
		end
	endtask

	always @(posedge clk) begin
		capture_result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result beat with nothing pending: %h", m_axis_tdata);
				failed = 1;
			end else begin
				e = pending_q.pop_front();
				check_field("status", e.status, m_axis_tdata[2:0]);
				check_field("read_id", e.id, m_axis_tdata[31:3]);
				check_field("read_extended", e.ext, m_axis_tdata[32]);
				check_field("read_transmit", e.tx, m_axis_tdata[33]);
				check_field("read_bus", e.bus, m_axis_tdata[35:34]);
				check_field("read_length", e.len, m_axis_tdata[39:36]);
				check_field("read_payload", e.pay, m_axis_tdata[103:40]);
				check_field("read_time", e.ts, m_axis_tdata[151:104]);
				check_field("fill_level", e.fill, m_axis_tdata[160:152]);
				check_field("overflow_count", e.ovf, m_axis_tdata[192:161]);
				check_field("distinct_ids", e.seen, m_axis_tdata[201:193]);
				check_field("captured_count", e.cap, m_axis_tdata[233:202]);
			end
		end
	end

	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 0;
			end else
				m_axis_tready = ($urandom_range(99) >= snk_pct);
		end
	end

	task automatic wait_drained();
		while (pending_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ID_LOW:    lo_bound = val[28:0];
			REG_ID_HIGH:   hi_bound = val[28:0];
			REG_DROP_REQ:  drop_req = val[0];
			REG_DROP_RESP: drop_resp = val[0];
			default:       cap_en = val[0];
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_frame(can_frame_t f, bit has_status, status_t st);
		capture_result_t r;
		while ($urandom_range(99) < src_pct)
			@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = '0;
		s_axis_tdata[1:0] = f.act;
		s_axis_tdata[30:2] = f.id;
		s_axis_tdata[31] = f.ext;
		s_axis_tdata[32] = f.tx;
		s_axis_tdata[34:33] = f.bus;
		s_axis_tdata[38:35] = f.len;
		s_axis_tdata[102:39] = f.pay;
		s_axis_tdata[150:103] = f.ts;
		do @(posedge clk); while (!s_axis_tready);
		r = capture_step(f);
		if (has_status)
			r.status = st;
		pending_q.push_back(r);
		@(negedge clk);
		s_axis_tvalid = 0;
	endtask

	function automatic can_frame_t make_frame(action_t a, logic [28:0] id);
		can_frame_t f;
		f.act = a;
		f.id = id;
		f.ext = 1'($urandom_range(1));
		f.tx = 1'($urandom_range(1));
		f.bus = 2'($urandom_range(3));
		f.len = 4'(($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8));
		f.pay = {$urandom, $urandom};
		f.ts = 48'({$urandom, $urandom});
		return f;
	endfunction

	function automatic logic [28:0] pick_id();
		case ($urandom_range(9))
			0: return lo_bound;
			1: return hi_bound;
			2: return lo_bound - 1'b1;
			3: return hi_bound + 1'b1;
			4: return OBD_REQUEST_ID;
			5: return 29'(OBD_RESP_FIRST + $urandom_range(7));
			6: return 29'($urandom);
			default: return 29'($urandom_range(hi_bound, lo_bound));
		endcase
	endfunction

	task automatic random_frames(int n, int offer_pct, bit allow_clear);
		action_t a;
		int roll;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < offer_pct)
				a = ACT_OFFER;
			else if (allow_clear && roll < offer_pct + 2)
				a = ACT_CLEAR;
			else if (roll < offer_pct + 5)
				a = ACT_NONE;
			else
				a = ACT_READ;
			send_frame(make_frame(a, pick_id()), 0, ST_STORED);
		end
	endtask

	task automatic set_filter(logic [28:0] lo, logic [28:0] hi, bit dq, bit dr, bit en);
		wait_drained();
		write_reg(REG_ID_LOW, 32'(lo));
		write_reg(REG_ID_HIGH, 32'(hi));
		write_reg(REG_DROP_REQ, 32'(dq));
		write_reg(REG_DROP_RESP, 32'(dr));
		write_reg(REG_CAPTURE, 32'(en));
	endtask

	task automatic random_filter();
		logic [28:0] lo, hi;
		case ($urandom_range(3))
			0: begin lo = 0; hi = STD_ID_MAX; end
			1: begin lo = 29'h7D0; hi = 29'h7F0; end
			2: begin lo = 29'($urandom); hi = 29'($urandom); end
			default: begin
				lo = 29'($urandom_range(29'h7E0));
				hi = 29'($urandom_range(29'h800, 29'h7E0));
			end
		endcase
		set_filter(lo, hi, 1'($urandom_range(1)), 1'($urandom_range(1)),
			$urandom_range(9) != 0);
	endtask

	function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [31:0] val);
		stim_row_t r;
		r.is_cfg = 1;
		r.reg_idx = idx;
		r.reg_val = val;
		r.frame = make_frame(ACT_OFFER, '0);
		r.has_status = 0;
		r.status = ST_STORED;
		return r;
	endfunction

	function automatic stim_row_t item_row(action_t a, logic [28:0] id, bit hs, status_t st);
		stim_row_t r;
		r.is_cfg = 0;
		r.reg_idx = REG_ID_LOW;
		r.reg_val = '0;
		r.frame = make_frame(a, id);
		r.has_status = hs;
		r.status = st;
		return r;
	endfunction

	initial begin
		stim_row_t rows[$];
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_ID_LOW;
		cfg_data = '0;
		failed = 0;
		cycles = 0;
		src_pct = 0;
		snk_pct = 0;
		hold_left = 0;
		lo_bound = 0;
		hi_bound = STD_ID_MAX;
		drop_req = 1;
		drop_resp = 0;
		cap_en = 0;
		wr_ptr = 0;
		rd_ptr = 0;
		fill_cnt = 0;
		key_cnt = 0;
		lost_total = 0;
		stored_total = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		rows.push_back(item_row(ACT_OFFER, 0, 1, ST_DISABLED));
		rows.push_back(item_row(ACT_READ, 0, 1, ST_READ_EMPTY));
		rows.push_back(item_row(ACT_NONE, 29'h1FFFFFFF, 1, ST_DISABLED));
		rows.push_back(cfg_row(REG_CAPTURE, 1));
		rows.push_back(item_row(ACT_OFFER, 0, 1, ST_STORED));
		rows.push_back(item_row(ACT_OFFER, STD_ID_MAX, 1, ST_STORED));
		rows.push_back(item_row(ACT_OFFER, OBD_REQUEST_ID, 1, ST_FILTERED));
		rows.push_back(item_row(ACT_OFFER, 29'h800, 1, ST_FILTERED));
		rows.push_back(item_row(ACT_OFFER, OBD_RESP_FIRST, 1, ST_STORED));
		rows.push_back(item_row(ACT_READ, 0, 0, ST_STORED));
		rows.push_back(cfg_row(REG_DROP_RESP, 1));
		rows.push_back(cfg_row(REG_DROP_REQ, 0));
		rows.push_back(item_row(ACT_OFFER, OBD_RESP_FIRST, 1, ST_FILTERED));
		rows.push_back(item_row(ACT_OFFER, OBD_RESP_LAST, 1, ST_FILTERED));
		rows.push_back(item_row(ACT_OFFER, OBD_REQUEST_ID, 1, ST_STORED));
		rows.push_back(item_row(ACT_OFFER, 29'h7F0, 1, ST_STORED));
		rows.push_back(cfg_row(REG_ID_LOW, 32'h1FFFFFFF));
		rows.push_back(cfg_row(REG_ID_HIGH, 0));
		rows.push_back(item_row(ACT_OFFER, 29'h1FFFFFFF, 1, ST_FILTERED));
		rows.push_back(item_row(ACT_OFFER, 0, 1, ST_FILTERED));
		rows.push_back(cfg_row(REG_ID_LOW, 0));
		rows.push_back(cfg_row(REG_ID_HIGH, 32'h1FFFFFFF));
		rows.push_back(item_row(ACT_OFFER, 29'h1FFFFFFF, 1, ST_STORED));
		rows.push_back(item_row(ACT_OFFER, 29'h10000, 0, ST_STORED));
		rows.push_back(item_row(ACT_READ, 0, 0, ST_STORED));
		rows.push_back(item_row(ACT_READ, 0, 0, ST_STORED));
		rows.push_back(item_row(ACT_CLEAR, 0, 1, ST_STORED));
		rows.push_back(item_row(ACT_READ, 0, 1, ST_READ_EMPTY));
		rows[5].frame.ext = 1;
		rows[5].frame.tx = 1;
		rows[5].frame.bus = 3;
		rows[5].frame.len = 8;
		rows[5].frame.pay = '1;
		rows[5].frame.ts = '1;
		rows[4].frame.ext = 0;
		rows[4].frame.tx = 0;
		rows[4].frame.bus = 0;
		rows[4].frame.len = 0;
		rows[4].frame.pay = '0;
		rows[4].frame.ts = '0;
		rows[15].frame.len = 15;
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_drained();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			end else
				send_frame(rows[i].frame, rows[i].has_status, rows[i].status);
		end

		// fill the ring and the key table past capacity
		set_filter(0, 29'h1FFFFFFF, 1, 1, 1);
		for (int i = 0; i < 300; i++)
			send_frame(make_frame(ACT_OFFER, 29'(i * 5 + 'h100)), 0, ST_STORED);

		random_filter();
		src_pct = 55;
		random_frames(120, 70, 1);

		set_filter(29'h1FFFFFFF, 29'h1FFFFFFF, 0, 0, 1);
		src_pct = 0;
		snk_pct = 55;
		random_frames(60, 70, 1);

		random_filter();
		snk_pct = 0;
		hold_left = 3000;
		random_frames(20, 80, 0);
		snk_pct = 55;
		random_frames(40, 70, 1);

		random_filter();
		src_pct = 18;
		snk_pct = 18;
		random_frames(100, 70, 1);
		wait_drained();
		random_frames(60, 70, 1);

		set_filter(0, STD_ID_MAX, 1, 0, 1);
		src_pct = 0;
		snk_pct = 0;
		random_frames(60, 70, 1);

		wait_drained();
		if (!failed)
			$display("[can_frame_capture_filter_unit] OK");
		else
			$display("[can_frame_capture_filter_unit] ERROR");
		$finish;
	end

endmodule
